@@ rtl/symbol_table_hash_lookup_insert_assert.svh @@
// ============================================================================
// Symbol table assertion macros
// Shared property shapes for the symbol table checks.
// ============================================================================
`ifndef SYMBOL_TABLE_HASH_LOOKUP_INSERT_ASSERT_SVH
`define SYMBOL_TABLE_HASH_LOOKUP_INSERT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define STHL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("symbol table check failed");

// Next-cycle implication, disabled in reset.
`define STHL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("symbol table check failed");

`endif

@@ rtl/sthl_pkg.sv @@
// ============================================================================
// Symbol table package
// Request/response payloads, codes and control groups.
// ============================================================================
package sthl_pkg;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] name_byte;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] entry_index;
    } t_out_rsp;

    typedef struct packed {
        logic push;
        logic clear;
    } t_name_ctl;

    typedef struct packed {
        logic bkt_rd;
        logic bkt_wr;
        logic meta_rd;
        logic next_wr;
        logic len_wr;
        logic byte_wr;
        logic byte_rd;
    } t_store_ctl;

endpackage

@@ rtl/sthl_name.sv @@
// ============================================================================
// Symbol table name buffer
// Holds the incoming name, its length and the running bucket number.
// ============================================================================
module sthl_name #(
    parameter int MAX_NAME = 32,
    parameter int BUCKETS  = 256,
    localparam int NW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1,
    localparam int LW = $clog2(MAX_NAME + 1),
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sthl_pkg::t_name_ctl  i_ctl,
    input  logic [7:0]           i_byte,
    input  logic [NW-1:0]        i_rd_addr,
    output logic [7:0]           o_rd_byte,
    output logic [LW-1:0]        o_len,
    output logic [BW-1:0]        o_bucket
);
    localparam int XW = BW + 9;

    logic [7:0]    r_mem [2**NW];
    logic [7:0]    r_rd_byte;
    logic [LW-1:0] r_len;
    logic [BW-1:0] r_bkt;
    logic [BW-1:0] n_bkt;
    logic          keep;
    logic [XW-1:0] acc;

    assign keep = i_ctl.push && (r_len < LW'(MAX_NAME));

    // (bucket + byte) mod BUCKETS by restoring compare-subtract; quotient < 256
    always_comb begin
        acc = XW'(r_bkt) + XW'(i_byte);
        for (int j = 7; j >= 0; j--) begin
            if (acc >= (XW'(BUCKETS) << j)) begin
                acc = acc - (XW'(BUCKETS) << j);
            end
        end
        n_bkt = BW'(acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_bkt <= '0;
        end else if (i_ctl.clear) begin
            r_len <= '0;
            r_bkt <= '0;
        end else if (keep) begin
            r_len <= r_len + LW'(1);
            r_bkt <= n_bkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_mem[r_len[NW-1:0]] <= i_byte;
        end
        r_rd_byte <= r_mem[i_rd_addr];
    end

    assign o_rd_byte = r_rd_byte;
    assign o_len     = r_len;
    assign o_bucket  = r_bkt;
endmodule

@@ rtl/sthl_store.sv @@
// ============================================================================
// Symbol table store
// Bucket head/tail memory and the per-entry link, length and byte memories.
// ============================================================================
module sthl_store #(
    parameter int MAX_NAME    = 32,
    parameter int BUCKETS     = 256,
    parameter int MAX_ENTRIES = 256,
    localparam int NW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1,
    localparam int LW = $clog2(MAX_NAME + 1),
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int EW = $clog2(MAX_ENTRIES),
    localparam int PW = EW + 1
) (
    input  logic                 i_clk,
    input  sthl_pkg::t_store_ctl i_ctl,
    input  logic [BW-1:0]        i_bkt_addr,
    input  logic [PW-1:0]        i_bkt_head,
    input  logic [EW-1:0]        i_bkt_tail,
    output logic [PW-1:0]        o_bkt_head,
    output logic [EW-1:0]        o_bkt_tail,
    input  logic [EW-1:0]        i_meta_addr,
    input  logic [PW-1:0]        i_next_data,
    input  logic [LW-1:0]        i_len_data,
    output logic [PW-1:0]        o_next,
    output logic [LW-1:0]        o_len,
    input  logic [EW+NW-1:0]     i_byte_wr_addr,
    input  logic [7:0]           i_byte_data,
    input  logic [EW+NW-1:0]     i_byte_rd_addr,
    output logic [7:0]           o_byte
);
    logic [PW+EW-1:0] r_bkt_mem  [BUCKETS];
    logic [PW-1:0]    r_next_mem [2**EW];
    logic [LW-1:0]    r_len_mem  [2**EW];
    logic [7:0]       r_byte_mem [2**(EW+NW)];
    logic [PW+EW-1:0] r_bkt_rd;
    logic [PW-1:0]    r_next_rd;
    logic [LW-1:0]    r_len_rd;
    logic [7:0]       r_byte_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.bkt_wr) begin
            r_bkt_mem[i_bkt_addr] <= {i_bkt_head, i_bkt_tail};
        end
        if (i_ctl.bkt_rd) begin
            r_bkt_rd <= r_bkt_mem[i_bkt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.next_wr) begin
            r_next_mem[i_meta_addr] <= i_next_data;
        end
        if (i_ctl.meta_rd) begin
            r_next_rd <= r_next_mem[i_meta_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.len_wr) begin
            r_len_mem[i_meta_addr] <= i_len_data;
        end
        if (i_ctl.meta_rd) begin
            r_len_rd <= r_len_mem[i_meta_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_wr) begin
            r_byte_mem[i_byte_wr_addr] <= i_byte_data;
        end
        if (i_ctl.byte_rd) begin
            r_byte_rd <= r_byte_mem[i_byte_rd_addr];
        end
    end

    assign o_bkt_head = r_bkt_rd[PW+EW-1:EW];
    assign o_bkt_tail = r_bkt_rd[EW-1:0];
    assign o_next     = r_next_rd;
    assign o_len      = r_len_rd;
    assign o_byte     = r_byte_rd;
endmodule

@@ rtl/symbol_table_hash_lookup_insert.sv @@
// ============================================================================
// Symbol table hash lookup/insert
// Interning table with separate chaining: lookup or insert a streamed name.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in_req)
//  out     | output    | o_out_valid/i_out_ready | o_out_data (t_out_rsp)
//
// A non-final byte request leaves the sequencer in S_IDLE; bytes can stream back to back.
// A final byte starts a bucket read and a walk down the chain, comparing each
//   entry's length and, when lengths match, its bytes; a miss on insert writes
//   the new entry and, if the bucket was not empty, links it after the old tail.
//   The walk runs through the single-port entry memories.
// After reset a clearing pass over all BUCKETS buckets empties the bucket heads;
//   no request is taken meanwhile.
// A waiting result does not block the next name; its walk runs, then the
//   input stalls until the single result register frees up.
// ============================================================================
module symbol_table_hash_lookup_insert #(
    parameter int MAX_NAME    = 32,
    parameter int BUCKETS     = 256,
    parameter int MAX_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sthl_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sthl_pkg::t_out_rsp o_out_data
);
    localparam int NW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int LW = $clog2(MAX_NAME + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int PW = EW + 1;                 // entry pointer, MSB = null
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [PW-1:0] NIL = {1'b1, {EW{1'b0}}};

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_BKT_RD   = 11'b00000000100,
        S_BKT_WT   = 11'b00000001000,
        S_META_RD  = 11'b00000010000,
        S_META_WT  = 11'b00000100000,
        S_BYTE_RD  = 11'b00001000000,
        S_BYTE_CMP = 11'b00010000000,
        S_INS      = 11'b00100000000,
        S_LINK     = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } t_state;

    t_state               r_state;
    logic [BW-1:0]        r_clr_addr;
    logic [CW-1:0]        r_count;
    logic                 r_op;
    logic [PW-1:0]        r_cur;     // entry being compared
    logic [PW-1:0]        r_next;    // its successor
    logic [PW-1:0]        r_head;
    logic [EW-1:0]        r_tail;
    logic [NW-1:0]        r_k;       // byte position in compare
    logic [1:0]           r_res_status;
    logic [7:0]           r_res_index;
    logic                 r_out_valid;
    sthl_pkg::t_out_rsp   r_out;

    sthl_pkg::t_name_ctl  name_ctl;
    sthl_pkg::t_store_ctl st_ctl;
    logic [7:0]           name_rd_byte;
    logic [LW-1:0]        name_len;
    logic [BW-1:0]        name_bkt;
    logic [BW-1:0]        bkt_addr;
    logic [PW-1:0]        bkt_head_wr;
    logic [EW-1:0]        bkt_tail_wr;
    logic [PW-1:0]        bkt_head_rd;
    logic [EW-1:0]        bkt_tail_rd;
    logic [EW-1:0]        meta_addr;
    logic [PW-1:0]        next_wr;
    logic [PW-1:0]        ent_next;
    logic [LW-1:0]        ent_len;
    logic [7:0]           ent_byte;
    logic                 in_fire;
    logic                 out_free;
    logic                 has_room;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign has_room = r_count < CW'(MAX_ENTRIES);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- name buffer: bytes, length, running bucket ----
    assign name_ctl.push  = in_fire;
    assign name_ctl.clear = (r_state == S_DONE) && out_free;

    sthl_name #(
        .MAX_NAME (MAX_NAME),
        .BUCKETS  (BUCKETS)
    ) u_name (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (name_ctl),
        .i_byte    (i_in_data.name_byte),
        .i_rd_addr (r_k),
        .o_rd_byte (name_rd_byte),
        .o_len     (name_len),
        .o_bucket  (name_bkt)
    );

    // ---- store control ----
    // Incoming bytes are also staged straight into the next free entry slot,
    // so an insert needs no copy pass.
    always_comb begin
        st_ctl.bkt_rd  = (r_state == S_BKT_RD);
        st_ctl.bkt_wr  = (r_state == S_CLEAR) || (r_state == S_INS);
        st_ctl.meta_rd = (r_state == S_META_RD);
        st_ctl.next_wr = (r_state == S_INS) || (r_state == S_LINK);
        st_ctl.len_wr  = (r_state == S_INS);
        st_ctl.byte_wr = in_fire && has_room && (name_len < LW'(MAX_NAME));
        st_ctl.byte_rd = (r_state == S_BYTE_RD);
    end

    assign bkt_addr    = (r_state == S_CLEAR) ? r_clr_addr : name_bkt;
    assign bkt_head_wr = (r_state == S_CLEAR) ? NIL
                       : (r_head[PW-1] ? {1'b0, r_count[EW-1:0]} : r_head);
    assign bkt_tail_wr = (r_state == S_CLEAR) ? '0 : r_count[EW-1:0];

    always_comb begin
        meta_addr = r_cur[EW-1:0];
        next_wr   = NIL;
        case (r_state)
            S_INS: begin
                meta_addr = r_count[EW-1:0];
                next_wr   = NIL;
            end
            S_LINK: begin
                meta_addr = r_tail;
                next_wr   = {1'b0, r_count[EW-1:0]};
            end
            default: begin
                meta_addr = r_cur[EW-1:0];
                next_wr   = NIL;
            end
        endcase
    end

    sthl_store #(
        .MAX_NAME    (MAX_NAME),
        .BUCKETS     (BUCKETS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk          (i_clk),
        .i_ctl          (st_ctl),
        .i_bkt_addr     (bkt_addr),
        .i_bkt_head     (bkt_head_wr),
        .i_bkt_tail     (bkt_tail_wr),
        .o_bkt_head     (bkt_head_rd),
        .o_bkt_tail     (bkt_tail_rd),
        .i_meta_addr    (meta_addr),
        .i_next_data    (next_wr),
        .i_len_data     (name_len),
        .o_next         (ent_next),
        .o_len          (ent_len),
        .i_byte_wr_addr ({r_count[EW-1:0], name_len[NW-1:0]}),
        .i_byte_data    (i_in_data.name_byte),
        .i_byte_rd_addr ({r_cur[EW-1:0], r_k}),
        .o_byte         (ent_byte)
    );

    // ---- sequencer: clear, collect, walk chain, insert, respond ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the result register itself
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BW'(1);
                    if (r_clr_addr == BW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire && i_in_data.last) begin
                        r_op    <= i_in_data.op;
                        r_state <= S_BKT_RD;
                    end
                end
                S_BKT_RD: begin
                    r_state <= S_BKT_WT;
                end
                S_BKT_WT: begin
                    r_head  <= bkt_head_rd;
                    r_tail  <= bkt_tail_rd;
                    r_cur   <= bkt_head_rd;
                    r_state <= S_META_RD;
                end
                S_META_RD: begin
                    r_k <= '0;
                    if (!r_cur[PW-1]) begin
                        r_state <= S_META_WT;
                    end else if (r_op == sthl_pkg::OP_INSERT && has_room) begin
                        r_state <= S_INS;
                    end else begin
                        // miss: lookup, or insert into a full table
                        r_res_status <= (r_op == sthl_pkg::OP_INSERT)
                                      ? sthl_pkg::ST_FULL : sthl_pkg::ST_NOT_FOUND;
                        r_res_index  <= '0;
                        r_state      <= S_DONE;
                    end
                end
                S_META_WT: begin
                    r_next <= ent_next;
                    if (ent_len == name_len) begin
                        r_state <= S_BYTE_RD;
                    end else begin
                        r_cur   <= ent_next;
                        r_state <= S_META_RD;
                    end
                end
                S_BYTE_RD: begin
                    r_state <= S_BYTE_CMP;
                end
                S_BYTE_CMP: begin
                    if (ent_byte != name_rd_byte) begin
                        r_cur   <= r_next;
                        r_state <= S_META_RD;
                    end else if (LW'(r_k) + LW'(1) == name_len) begin
                        r_res_status <= sthl_pkg::ST_FOUND;
                        r_res_index  <= 8'(r_cur[EW-1:0]);
                        r_state      <= S_DONE;
                    end else begin
                        r_k     <= r_k + NW'(1);
                        r_state <= S_BYTE_RD;
                    end
                end
                S_INS: begin
                    r_res_status <= sthl_pkg::ST_INSERTED;
                    r_res_index  <= 8'(r_count[EW-1:0]);
                    if (r_head[PW-1]) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.status      <= r_res_status;
            r_out.entry_index <= r_res_index;
        end
    end

    // ---- checks ----
    `include "symbol_table_hash_lookup_insert_assert.svh"

    `STHL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(MAX_ENTRIES))
    `STHL_ASSERT_IMPL(a_ready_idle, o_in_ready, r_state == S_IDLE)
    `STHL_ASSERT_IMPL(a_miss_index_zero, o_out_valid && (o_out_data.status == sthl_pkg::ST_NOT_FOUND || o_out_data.status == sthl_pkg::ST_FULL), o_out_data.entry_index == 8'd0)
    `STHL_ASSERT_IMPL(a_count_step, $past(i_rst_n) && r_count != $past(r_count), r_count == $past(r_count) + CW'(1))

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Symbol table hash lookup/insert testbench
// Streams names into the table through its request channel and predicts each
// lookup or insert answer with its own model of the chained buckets. Covers
// short and long names, a zero byte, op handling, back pressure and a full table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NAME    = 32;
    localparam int BUCKETS     = 256;
    localparam int MAX_ENTRIES = 256;
    localparam int NIL         = 'h1FF;
    localparam int WDOG_LIMIT  = 60000;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sthl_pkg::t_in_req  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    sthl_pkg::t_out_rsp o_out_data;

    symbol_table_hash_lookup_insert dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Table model: pending name plus chained entries.
    logic [7:0] cur_bytes [MAX_NAME];
    int         cur_len;
    int         cur_sum;
    int         head [BUCKETS];
    int         tail [BUCKETS];
    int         nxt [MAX_ENTRIES];
    logic [7:0] ent_bytes [MAX_ENTRIES][MAX_NAME];
    int         ent_len [MAX_ENTRIES];
    int         ent_count;

    sthl_pkg::t_out_rsp answers_q[$];
    int         fails;
    bit         quiet;      // no idling on either side
    bit         hold_req;   // ask receiver for a long hold-off

    // Name under construction for send_name, plus a pool of names for reuse.
    logic [7:0] nm [48];
    int         nm_len;
    logic [7:0] pool [64][48];
    int         pool_len [64];
    int         pool_n;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one accepted request to the model; queue an answer on last.
    task automatic table_step(input sthl_pkg::t_in_req r);
        int bkt;
        int cur;
        int steps;
        int hit;
        bit same;
        sthl_pkg::t_out_rsp ans;
        if (cur_len < MAX_NAME) begin
            cur_bytes[cur_len] = r.name_byte;
            cur_len++;
            cur_sum += r.name_byte;
        end
        if (!r.last) return;
        bkt = cur_sum % BUCKETS;
        hit = NIL;
        cur = head[bkt];
        steps = 0;
        while (cur != NIL && cur < ent_count && steps < ent_count && hit == NIL) begin
            same = (ent_len[cur] == cur_len);
            for (int i = 0; i < cur_len && same; i++)
                if (ent_bytes[cur][i] != cur_bytes[i]) same = 1'b0;
            if (same) hit = cur;
            else begin
                cur = nxt[cur];
                steps++;
            end
        end
        ans.status = sthl_pkg::ST_NOT_FOUND;
        ans.entry_index = '0;
        if (hit != NIL) begin
            ans.status = sthl_pkg::ST_FOUND;
            ans.entry_index = hit[7:0];
        end else if (r.op == sthl_pkg::OP_INSERT) begin
            if (ent_count >= MAX_ENTRIES) begin
                ans.status = sthl_pkg::ST_FULL;
            end else begin
                for (int i = 0; i < cur_len; i++) ent_bytes[ent_count][i] = cur_bytes[i];
                ent_len[ent_count] = cur_len;
                nxt[ent_count] = NIL;
                if (head[bkt] == NIL) head[bkt] = ent_count;
                else nxt[tail[bkt]] = ent_count;
                tail[bkt] = ent_count;
                ans.status = sthl_pkg::ST_INSERTED;
                ans.entry_index = ent_count[7:0];
                ent_count++;
            end
        end
        answers_q.push_back(ans);
        cur_len = 0;
        cur_sum = 0;
    endtask

    // Offer one request; valid stays high into the next call unless an idle gap is taken.
    task automatic send_req(input logic op, input logic [7:0] b, input logic last);
        sthl_pkg::t_in_req r;
        r.op = op;
        r.name_byte = b;
        r.last = last;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = r;
        do @(posedge i_clk); while (!o_in_ready);
        table_step(r);
    endtask

    // Send nm[0..nm_len-1]; earlier bytes carry random ops, only the last one counts.
    task automatic send_name(input logic op);
        for (int i = 0; i < nm_len; i++)
            send_req((i == nm_len - 1) ? op : logic'($urandom_range(1)), nm[i],
                     i == nm_len - 1);
    endtask

    task automatic remember_name();
        int k;
        if (pool_n < 64) begin
            k = pool_n;
            pool_n = pool_n + 1;
        end else begin
            k = $urandom_range(63);
        end
        for (int i = 0; i < nm_len; i++) pool[k][i] = nm[i];
        pool_len[k] = nm_len;
    endtask

    // Short names over a small alphabet collide often; some use the full byte range.
    task automatic make_random_name();
        int k;
        if (pool_n > 0 && $urandom_range(99) < 40) begin
            k = $urandom_range(pool_n - 1);
            nm_len = pool_len[k];
            for (int i = 0; i < nm_len; i++) nm[i] = pool[k][i];
        end else begin
            nm_len = ($urandom_range(19) == 0) ? $urandom_range(48, 30) : $urandom_range(5, 1);
            for (int i = 0; i < nm_len; i++)
                nm[i] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(8'h64, 8'h61));
        end
    endtask

    task automatic test_directed();
        nm_len = 1; nm[0] = 8'h61;
        send_name(sthl_pkg::OP_LOOKUP);        // miss on empty table
        send_name(sthl_pkg::OP_INSERT);        // new entry
        send_name(sthl_pkg::OP_LOOKUP);        // found
        send_name(sthl_pkg::OP_INSERT);        // insert of existing name
        nm[0] = 8'hFF; send_name(sthl_pkg::OP_INSERT);
        nm[0] = 8'h01; send_name(sthl_pkg::OP_INSERT);
        nm[0] = 8'h00; send_name(sthl_pkg::OP_INSERT);   // zero byte kept like any other
        nm_len = 2; nm[0] = 8'h00; nm[1] = 8'h01;
        send_name(sthl_pkg::OP_INSERT);        // same sum as the single 1 byte
        nm[0] = 8'h01; nm[1] = 8'h00;
        send_name(sthl_pkg::OP_LOOKUP);
        // Only the op on the final byte matters.
        nm_len = 3; nm[0] = 8'h71; nm[1] = 8'h72; nm[2] = 8'h73;
        send_req(sthl_pkg::OP_INSERT, nm[0], 1'b0);
        send_req(sthl_pkg::OP_INSERT, nm[1], 1'b0);
        send_req(sthl_pkg::OP_LOOKUP, nm[2], 1'b1);
        // Long name: tail beyond the kept length is ignored.
        nm_len = 40;
        for (int i = 0; i < 40; i++) nm[i] = 8'h41 + 8'(i);
        send_name(sthl_pkg::OP_INSERT);
        for (int i = MAX_NAME; i < 40; i++) nm[i] = 8'hEE;
        send_name(sthl_pkg::OP_LOOKUP);
        nm_len = MAX_NAME;
        send_name(sthl_pkg::OP_INSERT);
    endtask

    task automatic test_random(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            quiet = (sent > n_bytes / 3 && sent < n_bytes / 2);
            make_random_name();
            send_name(logic'($urandom_range(99) < 60));
            remember_name();
            sent += nm_len;
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 12; n++) begin
            make_random_name();
            send_name(logic'($urandom_range(1)));
        end
    endtask

    // Fill the store with one-byte names (two-byte ones once those run out), then insert more and check that
    // lookups still work.
    task automatic test_table_full();
        int k;
        k = 0;
        while (ent_count < MAX_ENTRIES) begin
            if (k < 256) begin
                nm_len = 1; nm[0] = 8'(k);
            end else begin
                nm_len = 2; nm[0] = 8'hF0 ^ 8'(k >> 8); nm[1] = 8'(k);
            end
            send_name(sthl_pkg::OP_INSERT);
            k++;
        end
        for (int n = 0; n < 6; n++) begin
            nm_len = 3; nm[0] = 8'h0F; nm[1] = 8'(n); nm[2] = 8'($urandom_range(255));
            send_name(sthl_pkg::OP_INSERT);
            nm_len = 2; nm[0] = 8'hF0; nm[1] = 8'($urandom_range(255));
            send_name(logic'($urandom_range(1)));
        end
    endtask

    // Receiver: random stalls, and one long hold-off when asked.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready = quiet || ($urandom_range(99) >= 17);
        end
    end

    // Result checker and watchdog.
    int idle_cycles;
    always @(posedge i_clk) begin
        sthl_pkg::t_out_rsp exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (answers_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d index=%0d", $time,
                             o_out_data.status, o_out_data.entry_index);
                    fails++;
                end else begin
                    exp_r = answers_q.pop_front();
                    if (o_out_data.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, o_out_data.status);
                        fails++;
                    end
                    if (o_out_data.entry_index !== exp_r.entry_index) begin
                        $display("%0t: entry_index expected %0d actual %0d", $time,
                                 exp_r.entry_index, o_out_data.entry_index);
                        fails++;
                    end
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        fails = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        pool_n = 0;
        idle_cycles = 0;
        cur_len = 0;
        cur_sum = 0;
        ent_count = 0;
        for (int i = 0; i < BUCKETS; i++) begin
            head[i] = NIL;
            tail[i] = 0;
        end
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(120);
        test_backpressure();
        test_table_full();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (answers_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
